### sv/infix_to_postfix_converter_assert.svh
// Assertion macros shared by the converter checker.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define I2P_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define I2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/i2p_pkg.sv
// Shared types, character codes and precedence functions for the converter.
package i2p_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_CHAR,
      HOLD_TOP,
      HOLD_MARK
   } hold_src_type;

   typedef struct packed {
      logic         cap;
      logic         rd;
      logic         push;
      logic         pop;
      logic         set_ovf;
      logic         clr_ovf;
      hold_src_type hold_src;
      logic         send;
      logic         send_last;
   } cmd_type;

   typedef struct packed {
      logic letter;
      logic is_end;
      logic empty;
      logic full;
      logic push_wins;
      logic paren_match;
      logic hold_vld;
      logic rsp_free;
   } status_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
   endfunction

   function automatic logic [2:0] out_rank(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         CH_PLUS, CH_MINUS:             r = 3'd1;
         CH_STAR, CH_PERCENT, CH_SLASH: r = 3'd3;
         CH_CARET:                      r = 3'd6;
         CH_LPAREN:                     r = 3'd7;
         default:                       r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] in_rank(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         CH_PLUS, CH_MINUS:             r = 3'd2;
         CH_STAR, CH_PERCENT, CH_SLASH: r = 3'd4;
         CH_CARET:                      r = 3'd5;
         default:                       r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

### sv/i2p_datapath.sv
// Datapath: operator stack memory, count, overflow flag, hold and result registers.
module i2p_datapath #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  i2p_pkg::cmd_type     cmd,
   output i2p_pkg::status_type  status,
   input  logic                 req_kind,
   input  logic [7:0]           req_char,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_char,
   output logic                 rsp_end,
   output logic                 rsp_last,
   output logic                 rsp_ovf
);
   import i2p_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    stack_ff [STACK_DEPTH];
   logic [7:0]    rd_ff;
   logic          kind_ff, kind_in;
   logic [7:0]    char_ff, char_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    hold_char_ff, hold_char_in;
   logic          hold_end_ff, hold_end_in;
   logic          hold_ovf_ff, hold_ovf_in;
   logic          hold_vld_ff, hold_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_end_ff, rsp_end_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic [CW-1:0] count_m1;
   logic          empty;

   assign count_m1 = count_ff - 1'b1;
   assign empty    = (count_ff == '0);

   // single write port at the free slot, registered read of the top entry
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_ff[count_ff[AW-1:0]] <= char_ff;
      end
      if (cmd.rd) begin
         rd_ff <= stack_ff[count_m1[AW-1:0]];
      end
   end

   always_comb begin
      kind_in      = cmd.cap ? req_kind : kind_ff;
      char_in      = cmd.cap ? req_char : char_ff;
      count_in     = count_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_m1;
      end
      ovf_in       = ovf_ff;
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end else if (cmd.clr_ovf) begin
         ovf_in = 1'b0;
      end

      hold_char_in = hold_char_ff;
      hold_end_in  = hold_end_ff;
      hold_ovf_in  = hold_ovf_ff;
      hold_vld_in  = cmd.send ? 1'b0 : hold_vld_ff;
      case (cmd.hold_src)
         HOLD_CHAR: begin
            hold_char_in = req_char;
            hold_end_in  = 1'b0;
            hold_ovf_in  = ovf_ff;
            hold_vld_in  = 1'b1;
         end
         HOLD_TOP: begin
            hold_char_in = rd_ff;
            hold_end_in  = 1'b0;
            hold_ovf_in  = ovf_ff;
            hold_vld_in  = 1'b1;
         end
         HOLD_MARK: begin
            hold_char_in = CH_NUL;
            hold_end_in  = 1'b1;
            hold_ovf_in  = ovf_ff;
            hold_vld_in  = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.send) begin
         rsp_char_in  = hold_char_ff;
         rsp_end_in   = hold_end_ff;
         rsp_last_in  = cmd.send_last;
         rsp_ovf_in   = hold_ovf_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      hold_char_ff <= hold_char_in;
      hold_end_ff  <= hold_end_in;
      hold_ovf_ff  <= hold_ovf_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.letter      = !req_kind && is_letter(req_char);
      status.is_end      = kind_ff;
      status.empty       = empty;
      status.full        = (count_ff == CW'(STACK_DEPTH));
      // an empty stack ranks below everything
      status.push_wins   = empty || (out_rank(char_ff) > in_rank(rd_ff));
      status.paren_match = !empty && (char_ff == CH_RPAREN) && (rd_ff == CH_LPAREN);
      status.hold_vld    = hold_vld_ff;
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_end   = rsp_end_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_ovf   = rsp_ovf_ff;

endmodule

### sv/i2p_ctrl.sv
// Controller: sequences reads, pops, pushes and result release for each item.
module i2p_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2p_pkg::status_type status,
   output i2p_pkg::cmd_type    cmd
);
   import i2p_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_DECIDE = 4'b0100,
      S_FIN    = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      can_emit;

   // a new result may enter hold only if the held one can move out now
   assign can_emit  = !status.hold_vld || status.rsp_free;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.hold_src = HOLD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (status.letter) begin
                  cmd.hold_src = HOLD_CHAR;
                  state_in     = S_FIN;
               end else begin
                  cmd.cap  = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.is_end && status.empty) begin
               if (can_emit) begin
                  cmd.hold_src = HOLD_MARK;
                  cmd.clr_ovf  = 1'b1;
                  cmd.send     = status.hold_vld;
                  state_in     = S_FIN;
               end
            end else if (!status.is_end && status.push_wins) begin
               if (status.full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
               state_in = status.hold_vld ? S_FIN : S_IDLE;
            end else if (!status.is_end && status.paren_match) begin
               cmd.pop  = 1'b1;
               state_in = status.hold_vld ? S_FIN : S_IDLE;
            end else if (can_emit) begin
               cmd.pop      = 1'b1;
               cmd.hold_src = HOLD_TOP;
               cmd.send     = status.hold_vld;
               state_in     = S_READ;
            end
         end
         S_FIN: begin
            if (status.rsp_free) begin
               cmd.send      = 1'b1;
               cmd.send_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/infix_to_postfix_converter.sv
// A letter goes into the hold register and then into the result register; no new item
// is taken until it has moved on. An operator first reads the stack top, then pushes, drops a
// matching ( or pops results one by one through hold; an end item pops every entry and then
// sends the end marker. The input is taken only while the controller is idle.
// Reset is synchronous: stack empty, overflow flag clear, no result pending;
// stack contents are left as they are.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic [1:0] rsp_tuser,   // [0] is_end_marker, [1] overflow_seen
   output logic       rsp_tlast
);
   import i2p_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       end_flag;
   logic       ovf_flag;

   i2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   i2p_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_kind  (req_tuser),
      .req_char  (req_tdata),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_char  (rsp_tdata),
      .rsp_end   (end_flag),
      .rsp_last  (rsp_tlast),
      .rsp_ovf   (ovf_flag)
   );

   assign rsp_tuser = {ovf_flag, end_flag};

endmodule

### sv/i2p_checker.sv
// Port-level checker for the converter, bound to the top level.
`include "infix_to_postfix_converter_assert.svh"

module i2p_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   logic        rsp_stall;
   logic        req_take;
   logic [11:0] rsp_word;
   logic        mark_seen;
   logic        mark_ok;
   logic        idle_ok;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_take  = req_tvalid && req_tready;
   assign rsp_word  = {rsp_tvalid, rsp_tlast, rsp_tuser, rsp_tdata};
   assign mark_seen = rsp_tvalid && rsp_tuser[0];
   assign mark_ok   = (rsp_tdata == 8'd0) && rsp_tlast;
   assign idle_ok   = !rsp_tvalid && req_tready;

   `I2P_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "stalled result moved")
   `I2P_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_tready, "input not held off")
   `I2P_ASSERT_NOW(a_end_marker_shape, clock, reset, mark_seen, mark_ok, "bad end marker")
   `I2P_ASSERT_NOW(a_reset_state, clock, reset, $past(reset), idle_ok, "not idle after reset")

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);

### tb/tb_infix_to_postfix_converter.sv
// Testbench for infix_to_postfix_converter: directed and random items checked by a predictor.
module tb_infix_to_postfix_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import i2p_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BACKTICK = 8'h60;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_ALL_ONES = 8'hFF;
   // Longest quiet stretch: a full flush, plus rare long receiver stalls.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_ITEMS    = 125;

   typedef struct {
      logic [7:0] ch;
      logic       is_end;
      logic       last;
      logic       ovf;
   } postfix_rsp_type;

   class postfix_scoreboard_type;
      logic [7:0]      op_stack [DEPTH];
      int              stack_fill;
      logic            overflow;
      postfix_rsp_type expected_postfix[$];
      int              errors;

      function new();
         stack_fill = 0;
         overflow   = 1'b0;
         errors     = 0;
      endfunction

      function bit letter_code(logic [7:0] c);
         return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
      endfunction

      function int prec_outside(logic [7:0] c);
         case (c)
            CH_PLUS, CH_MINUS:             return 1;
            CH_STAR, CH_PERCENT, CH_SLASH: return 3;
            CH_CARET:                      return 6;
            CH_LPAREN:                     return 7;
            default:                       return 0;
         endcase
      endfunction

      function int prec_inside(logic [7:0] c);
         case (c)
            CH_PLUS, CH_MINUS:             return 2;
            CH_STAR, CH_PERCENT, CH_SLASH: return 4;
            CH_CARET:                      return 5;
            default:                       return 0;
         endcase
      endfunction

      function int top_prec();
         if (stack_fill == 0) return -1;
         return prec_inside(op_stack[stack_fill - 1]);
      endfunction

      function postfix_rsp_type make_rsp(logic [7:0] c, logic endm);
         postfix_rsp_type r;
         r.ch     = c;
         r.is_end = endm;
         r.last   = 1'b0;
         r.ovf    = overflow;
         return r;
      endfunction

      function int pending_count();
         return expected_postfix.size();
      endfunction

      // Work out every character that one accepted item sends out.
      function void note_item(logic kind, logic [7:0] c);
         postfix_rsp_type batch[$];
         if (kind == KIND_END) begin
            while (stack_fill > 0) begin
               stack_fill--;
               batch.push_back(make_rsp(op_stack[stack_fill], 1'b0));
            end
            batch.push_back(make_rsp(CH_NUL, 1'b1));
            overflow = 1'b0;
         end else if (letter_code(c)) begin
            batch.push_back(make_rsp(c, 1'b0));
         end else begin
            while (1'b1) begin
               if (prec_outside(c) > top_prec()) begin
                  if (stack_fill >= DEPTH) begin
                     overflow = 1'b1;
                  end else begin
                     op_stack[stack_fill] = c;
                     stack_fill++;
                  end
                  break;
               end
               if (c == CH_RPAREN && op_stack[stack_fill - 1] == CH_LPAREN) begin
                  stack_fill--;
                  break;
               end
               stack_fill--;
               batch.push_back(make_rsp(op_stack[stack_fill], 1'b0));
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) expected_postfix.push_back(batch[i]);
      endfunction

      function void check_result(logic [7:0] data, logic [1:0] user, logic last_bit);
         postfix_rsp_type e;
         if (expected_postfix.size() == 0) begin
            $display("%0t: unexpected item char=%02h end=%0b ovf=%0b last=%0b",
                     $time, data, user[0], user[1], last_bit);
            errors++;
            return;
         end
         e = expected_postfix.pop_front();
         if (data !== e.ch) begin
            $display("%0t: char_out expected %02h got %02h", $time, e.ch, data);
            errors++;
         end
         if (user[0] !== e.is_end) begin
            $display("%0t: is_end_marker expected %0b got %0b", $time, e.is_end, user[0]);
            errors++;
         end
         if (user[1] !== e.ovf) begin
            $display("%0t: overflow_seen expected %0b got %0b", $time, e.ovf, user[1]);
            errors++;
         end
         if (last_bit !== e.last) begin
            $display("%0t: last expected %0b got %0b", $time, e.last, last_bit);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tuser = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   postfix_scoreboard_type sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Input items are noted before results are checked at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) sb.note_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("tb_infix_to_postfix_converter: FAIL");
      $finish;
   end

   // Leaves tvalid high on return so back-to-back items need no second assignment.
   task automatic send_item(input logic kind, input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(1)) return CH_UPPER_A + 8'($urandom_range(25));
      return CH_LOWER_A + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(5))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         3:       return CH_PERCENT;
         4:       return CH_SLASH;
         default: return CH_CARET;
      endcase
   endfunction

   task automatic send_expression();
      int terms;
      int open;
      int t;
      terms = $urandom_range(1, 7);
      open = 0;
      for (t = 0; t < terms; t++) begin
         if (t > 0) send_item(KIND_CHAR, pick_operator());
         while ($urandom_range(3) == 0) begin
            send_item(KIND_CHAR, CH_LPAREN);
            open++;
         end
         send_item(KIND_CHAR, pick_letter());
         while (open > 0 && $urandom_range(2) == 0) begin
            send_item(KIND_CHAR, CH_RPAREN);
            open--;
         end
      end
      while (open > 0) begin
         send_item(KIND_CHAR, CH_RPAREN);
         open--;
      end
      send_item(KIND_END, 8'($urandom_range(255)));
   endtask

   // Fill the stack near, to or past its top with ( and ^, which never pop each other.
   task automatic send_deep_run();
      int n;
      int i;
      n = $urandom_range(DEPTH - 4, DEPTH + 4);
      for (i = 0; i < n; i++) begin
         send_item(KIND_CHAR, $urandom_range(1) ? CH_LPAREN : CH_CARET);
         if ($urandom_range(3) == 0) send_item(KIND_CHAR, pick_letter());
      end
      if ($urandom_range(1)) send_item(KIND_CHAR, pick_operator());
      if ($urandom_range(1)) send_item(KIND_CHAR, CH_RPAREN);
      send_item(KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_item(KIND_END, 8'($urandom_range(255)));
         else send_item(KIND_CHAR, 8'($urandom_range(255)));
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      int stop_at;
      int pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) send_expression();
         else if (pick < 80) send_deep_run();
         else send_noise();
      end
   endtask

   initial begin
      logic [7:0] directed [$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Letter range edges, each operator, a paren pair, non-letter neighbors, NUL and 0xFF.
      directed = '{"A", CH_PLUS, "Z", CH_STAR, "a", CH_CARET, "z", CH_CARET, CH_LPAREN,
                   CH_MINUS, CH_PERCENT, CH_RPAREN, CH_SLASH, CH_AT, CH_LBRACK,
                   CH_BACKTICK, CH_LBRACE, CH_NUL, CH_ALL_ONES};
      send_idle_pct = 18;
      recv_idle_pct = 66;
      foreach (directed[i]) send_item(KIND_CHAR, directed[i]);
      send_item(KIND_END, CH_ALL_ONES);
      // Unmatched ) on an empty stack, then ) on top of ), then a flush and an empty flush.
      send_item(KIND_CHAR, CH_RPAREN);
      send_item(KIND_CHAR, CH_RPAREN);
      send_item(KIND_END, CH_NUL);
      send_item(KIND_END, CH_LPAREN);

      run_phase(18, 66);
      run_phase(66, 18);
      run_phase(0, 0);
      req_tvalid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("tb_infix_to_postfix_converter: PASS");
      end else begin
         $display("tb_infix_to_postfix_converter: FAIL");
      end
      $finish;
   end
endmodule
